[rtl/core/cpt_pkg.sv]
`timescale 1ns / 1ps
package cpt_pkg;

    // Default widths and fixed output width
    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_FRAC_BITS  = 8;
    localparam int CENTER_BITS    = 48;

    // Register stages in the geometry front end
    localparam int FRONT_LAT      = 5;

    // Per-item flags that ride alongside the divider
    typedef struct packed {
        logic circle_valid;
        logic in_circle;
    } t_side;

    // Signed width of the center numerators
    function automatic int num_bits(input int cb);
        return 3 * cb + 5;
    endfunction

    // Signed width of the determinant D
    function automatic int den_bits(input int cb);
        return 2 * cb + 4;
    endfunction

    // Divider latency: sign/magnitude stage, one stage per quotient bit, saturation
    function automatic int div_lat(input int cb, input int fb);
        return num_bits(cb) + fb + 2;
    endfunction

endpackage

[rtl/core/cpt_front.sv]
`timescale 1ns / 1ps
module cpt_front import cpt_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [COORD_BITS-1:0]                 i_ax,
    input  logic [COORD_BITS-1:0]                 i_ay,
    input  logic [COORD_BITS-1:0]                 i_bx,
    input  logic [COORD_BITS-1:0]                 i_by,
    input  logic [COORD_BITS-1:0]                 i_cx,
    input  logic [COORD_BITS-1:0]                 i_cy,
    input  logic [COORD_BITS-1:0]                 i_px,
    input  logic [COORD_BITS-1:0]                 i_py,
    output logic signed [den_bits(COORD_BITS)-1:0] o_den,
    output logic signed [num_bits(COORD_BITS)-1:0] o_num_x,
    output logic signed [num_bits(COORD_BITS)-1:0] o_num_y,
    output t_side                                 o_side
);

    localparam int CW   = COORD_BITS + 1;       // coordinate or difference
    localparam int PW   = 2 * CW;               // product of two of them
    localparam int SW   = 2 * COORD_BITS + 2;   // sum of two squares
    localparam int NPW  = SW + CW;              // numerator term
    localparam int NSW  = num_bits(COORD_BITS);
    localparam int DENW = den_bits(COORD_BITS);
    localparam int KW   = 2 * COORD_BITS + 3;   // 2x2 minor
    localparam int HW   = SW + KW;              // in-circle term
    localparam int DETW = 4 * COORD_BITS + 7;

    logic signed [CW-1:0] ax_s, ay_s, bx_s, by_s, cx_s, cy_s, px_s, py_s;

    assign ax_s = $signed({1'b0, i_ax});
    assign ay_s = $signed({1'b0, i_ay});
    assign bx_s = $signed({1'b0, i_bx});
    assign by_s = $signed({1'b0, i_by});
    assign cx_s = $signed({1'b0, i_cx});
    assign cy_s = $signed({1'b0, i_cy});
    assign px_s = $signed({1'b0, i_px});
    assign py_s = $signed({1'b0, i_py});

    // Stage 1: coordinates and differences
    logic signed [CW-1:0] r1_ax, r1_ay, r1_bx, r1_by, r1_cx, r1_cy;
    logic signed [CW-1:0] r1_e0, r1_e1, r1_e2, r1_f0, r1_f1, r1_f2;
    logic signed [CW-1:0] r1_pax, r1_pay, r1_pbx, r1_pby, r1_pcx, r1_pcy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax  <= ax_s;
            r1_ay  <= ay_s;
            r1_bx  <= bx_s;
            r1_by  <= by_s;
            r1_cx  <= cx_s;
            r1_cy  <= cy_s;
            r1_e0  <= by_s - cy_s;
            r1_e1  <= cy_s - ay_s;
            r1_e2  <= ay_s - by_s;
            r1_f0  <= cx_s - bx_s;
            r1_f1  <= ax_s - cx_s;
            r1_f2  <= bx_s - ax_s;
            r1_pax <= ax_s - px_s;
            r1_pay <= ay_s - py_s;
            r1_pbx <= bx_s - px_s;
            r1_pby <= by_s - py_s;
            r1_pcx <= cx_s - px_s;
            r1_pcy <= cy_s - py_s;
        end
    end

    // Stage 2: D terms, vertex norms, point-relative squares and cross products
    logic signed [PW-1:0] r2_t0, r2_t1, r2_t2;
    logic signed [SW-1:0] r2_sa, r2_sb, r2_sc, r2_qa, r2_qb, r2_qc;
    logic signed [PW-1:0] r2_m1, r2_m2, r2_m3, r2_m4, r2_m5, r2_m6;
    logic signed [CW-1:0] r2_e0, r2_e1, r2_e2, r2_f0, r2_f1, r2_f2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_t0 <= r1_ax * r1_e0;
            r2_t1 <= r1_bx * r1_e1;
            r2_t2 <= r1_cx * r1_e2;
            r2_sa <= SW'(r1_ax * r1_ax) + SW'(r1_ay * r1_ay);
            r2_sb <= SW'(r1_bx * r1_bx) + SW'(r1_by * r1_by);
            r2_sc <= SW'(r1_cx * r1_cx) + SW'(r1_cy * r1_cy);
            r2_qa <= SW'(r1_pax * r1_pax) + SW'(r1_pay * r1_pay);
            r2_qb <= SW'(r1_pbx * r1_pbx) + SW'(r1_pby * r1_pby);
            r2_qc <= SW'(r1_pcx * r1_pcx) + SW'(r1_pcy * r1_pcy);
            r2_m1 <= r1_pbx * r1_pcy;
            r2_m2 <= r1_pcx * r1_pby;
            r2_m3 <= r1_pax * r1_pcy;
            r2_m4 <= r1_pcx * r1_pay;
            r2_m5 <= r1_pax * r1_pby;
            r2_m6 <= r1_pbx * r1_pay;
            r2_e0 <= r1_e0;
            r2_e1 <= r1_e1;
            r2_e2 <= r1_e2;
            r2_f0 <= r1_f0;
            r2_f1 <= r1_f1;
            r2_f2 <= r1_f2;
        end
    end

    // Stage 3: D, numerator terms, minors
    logic signed [DENW-1:0] r3_d;
    logic signed [NPW-1:0]  r3_u0, r3_u1, r3_u2, r3_u3, r3_u4, r3_u5;
    logic signed [KW-1:0]   r3_k1, r3_k2, r3_k3;
    logic signed [SW-1:0]   r3_qa, r3_qb, r3_qc;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_d  <= (DENW'(r2_t0) + DENW'(r2_t1) + DENW'(r2_t2)) <<< 1;
            r3_u0 <= r2_sa * r2_e0;
            r3_u1 <= r2_sb * r2_e1;
            r3_u2 <= r2_sc * r2_e2;
            r3_u3 <= r2_sa * r2_f0;
            r3_u4 <= r2_sb * r2_f1;
            r3_u5 <= r2_sc * r2_f2;
            r3_k1 <= KW'(r2_m1) - KW'(r2_m2);
            r3_k2 <= KW'(r2_m3) - KW'(r2_m4);
            r3_k3 <= KW'(r2_m5) - KW'(r2_m6);
            r3_qa <= r2_qa;
            r3_qb <= r2_qb;
            r3_qc <= r2_qc;
        end
    end

    // Stage 4: numerators, in-circle terms
    logic signed [DENW-1:0] r4_d;
    logic signed [NSW-1:0]  r4_nx, r4_ny;
    logic signed [HW-1:0]   r4_h1, r4_h2, r4_h3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_d  <= r3_d;
            r4_nx <= NSW'(r3_u0) + NSW'(r3_u1) + NSW'(r3_u2);
            r4_ny <= NSW'(r3_u3) + NSW'(r3_u4) + NSW'(r3_u5);
            r4_h1 <= r3_qa * r3_k1;
            r4_h2 <= r3_qb * r3_k2;
            r4_h3 <= r3_qc * r3_k3;
        end
    end

    // Stage 5: in-circle determinant sign against sign of D
    logic signed [DETW-1:0] det;

    assign det = DETW'(r4_h1) - DETW'(r4_h2) + DETW'(r4_h3);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_den               <= r4_d;
            o_num_x             <= r4_nx;
            o_num_y             <= r4_ny;
            o_side.circle_valid <= (r4_d != '0);
            o_side.in_circle    <= (det != '0) && (det[DETW-1] == r4_d[DENW-1]);
        end
    end

endmodule

[rtl/core/cpt_div.sv]
`timescale 1ns / 1ps
module cpt_div import cpt_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [num_bits(COORD_BITS)-1:0] i_num,
    input  logic signed [den_bits(COORD_BITS)-1:0] i_den,
    output logic signed [CENTER_BITS-1:0]          o_quo,
    output logic                                   o_clip
);

    localparam int NSW  = num_bits(COORD_BITS);
    localparam int DENW = den_bits(COORD_BITS);
    localparam int NW   = NSW + FRAC_BITS;      // scaled dividend magnitude
    localparam int XW   = (NW > CENTER_BITS) ? NW : CENTER_BITS;
    localparam logic [XW-1:0] LIM_NEG = XW'(1) << (CENTER_BITS - 1);
    localparam logic [XW-1:0] LIM_POS = LIM_NEG - XW'(1);

    logic [DENW-1:0] r_rem [0:NW];
    logic [NW-1:0]   r_num [0:NW];
    logic [NW-1:0]   r_quo [0:NW];
    logic [DENW-1:0] r_dv  [0:NW];
    logic            r_neg [0:NW];

    logic [NSW-1:0]  num_mag;
    logic [DENW-1:0] den_mag;

    assign num_mag = i_num[NSW-1] ? NSW'(-i_num) : NSW'(i_num);
    assign den_mag = i_den[DENW-1] ? DENW'(-i_den) : DENW'(i_den);

    // Sign/magnitude split, dividend scaled by the fraction bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_num[0] <= NW'(num_mag) << FRAC_BITS;
            r_quo[0] <= '0;
            r_dv[0]  <= den_mag;
            r_neg[0] <= i_num[NSW-1] ^ i_den[DENW-1];
        end
    end

    // One restoring step per stage, quotient MSB first
    for (genvar k = 0; k < NW; k++) begin : g_step
        logic [DENW:0] trial;
        logic [DENW:0] diff;
        logic          ge;

        assign trial = {r_rem[k], r_num[k][NW-1]};
        assign diff  = trial - {1'b0, r_dv[k]};
        assign ge    = (trial >= {1'b0, r_dv[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
                r_num[k+1] <= r_num[k] << 1;
                r_quo[k+1] <= {r_quo[k][NW-2:0], ge};
                r_dv[k+1]  <= r_dv[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    // Sign restore and saturation to the output range
    logic [XW-1:0]          qx;
    logic [CENTER_BITS-1:0] mag;
    logic                   clip;

    assign qx   = XW'(r_quo[NW]);
    assign mag  = qx[CENTER_BITS-1:0];
    assign clip = r_neg[NW] ? (qx > LIM_NEG) : (qx > LIM_POS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_clip <= clip;
            if (clip) begin
                o_quo <= r_neg[NW] ? $signed(LIM_NEG[CENTER_BITS-1:0])
                                   : $signed(LIM_POS[CENTER_BITS-1:0]);
            end else begin
                o_quo <= r_neg[NW] ? $signed(~mag + 1'b1) : $signed(mag);
            end
        end
    end

endmodule

[rtl/core/circumcircle_point_test.sv]
`timescale 1ns / 1ps
// Circumcircle point test. Each transfer carries a triangle A, B, C and a query
// point P on an unsigned grid; each produces one result: circle_valid (zero for
// collinear vertices, which also zeroes every other field), point_inside (P
// strictly inside the circumcircle, decided exactly in integers), and the
// circumcenter as signed fixed point with FRAC_BITS fraction bits, truncated
// toward zero and saturated to 48 bits with center_clipped set. One item is
// accepted every cycle while no result is stalled at the output, and passes
// through the 5-stage geometry front end followed by a radix-2 divider that
// resolves one quotient bit per stage. The whole pipeline holds while a result
// is stalled at the output.
module circumcircle_point_test import cpt_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [COORD_BITS-1:0]         i_vert_a_x,
    input  logic [COORD_BITS-1:0]         i_vert_a_y,
    input  logic [COORD_BITS-1:0]         i_vert_b_x,
    input  logic [COORD_BITS-1:0]         i_vert_b_y,
    input  logic [COORD_BITS-1:0]         i_vert_c_x,
    input  logic [COORD_BITS-1:0]         i_vert_c_y,
    input  logic [COORD_BITS-1:0]         i_point_x,
    input  logic [COORD_BITS-1:0]         i_point_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_circle_valid,
    output logic                          o_point_inside,
    output logic signed [CENTER_BITS-1:0] o_center_x,
    output logic signed [CENTER_BITS-1:0] o_center_y,
    output logic                          o_center_clipped
);

    localparam int DIV_LAT = div_lat(COORD_BITS, FRAC_BITS);
    localparam int LAT     = FRONT_LAT + DIV_LAT;
    localparam int NSW     = num_bits(COORD_BITS);
    localparam int DENW    = den_bits(COORD_BITS);

    logic                   en;
    logic signed [DENW-1:0] den;
    logic signed [NSW-1:0]  num_x, num_y;
    t_side                  side;
    logic signed [CENTER_BITS-1:0] quo_x, quo_y;
    logic                   clip_x, clip_y;

    // Whole pipeline advances unless the output holds a stalled result
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    cpt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_ax    (i_vert_a_x),
        .i_ay    (i_vert_a_y),
        .i_bx    (i_vert_b_x),
        .i_by    (i_vert_b_y),
        .i_cx    (i_vert_c_x),
        .i_cy    (i_vert_c_y),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .o_den   (den),
        .o_num_x (num_x),
        .o_num_y (num_y),
        .o_side  (side)
    );

    cpt_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (num_x),
        .i_den  (den),
        .o_quo  (quo_x),
        .o_clip (clip_x)
    );

    cpt_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (num_y),
        .i_den  (den),
        .o_quo  (quo_y),
        .o_clip (clip_y)
    );

    // Valid bits for every stage
    logic r_vld [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < LAT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // Flags delayed to line up with the divider outputs
    t_side r_side [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Collinear triangles report all zeros
    assign o_valid          = r_vld[LAT-1];
    assign o_circle_valid   = r_side[DIV_LAT-1].circle_valid;
    assign o_point_inside   = r_side[DIV_LAT-1].circle_valid && r_side[DIV_LAT-1].in_circle;
    assign o_center_x       = r_side[DIV_LAT-1].circle_valid ? quo_x : '0;
    assign o_center_y       = r_side[DIV_LAT-1].circle_valid ? quo_y : '0;
    assign o_center_clipped = r_side[DIV_LAT-1].circle_valid && (clip_x || clip_y);

endmodule

[rtl/core/cpt_checker.sv]
`timescale 1ns / 1ps
module cpt_checker import cpt_pkg::*; (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_circle_valid,
    input logic                          o_point_inside,
    input logic signed [CENTER_BITS-1:0] o_center_x,
    input logic signed [CENTER_BITS-1:0] o_center_y,
    input logic                          o_center_clipped
);

    localparam logic [CENTER_BITS-1:0] CMIN = {1'b1, {(CENTER_BITS-1){1'b0}}};
    localparam logic [CENTER_BITS-1:0] CMAX = {1'b0, {(CENTER_BITS-1){1'b1}}};

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Input side stalls only when a finished result is held
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall not caused by output stall");

    // Degenerate triangle zeroes every result field
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_circle_valid) |-> (!o_point_inside && !o_center_clipped
            && o_center_x == '0 && o_center_y == '0))
        else $error("collinear triangle with nonzero result");

    // A clipped center shows a saturated coordinate
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_center_clipped) |-> (o_center_x == CMIN || o_center_x == CMAX
            || o_center_y == CMIN || o_center_y == CMAX))
        else $error("clip flag without saturated coordinate");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_center_x) && $stable(o_center_y)))
        else $error("stalled result changed");

endmodule

bind circumcircle_point_test cpt_checker u_cpt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_circle_valid   (o_circle_valid),
    .o_point_inside   (o_point_inside),
    .o_center_x       (o_center_x),
    .o_center_y       (o_center_y),
    .o_center_clipped (o_center_clipped)
);
